FILE: rtl/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int CMD_W       = 2;
  localparam int NOW_W       = 32;
  localparam int POS_W       = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int DUR_W       = 32;
  localparam int FC_W        = 5;
  localparam int OUT_FRAME_W = 4;
  localparam int PROG_W      = 16;
  localparam int PROD_W      = 2 * POS_W + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_DUR  = 2'd2;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_LOOP  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // Operation of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

FILE: rtl/sfs_alu.sv
`timescale 1ns / 1ps

module sfs_alu #(
  parameter int W = 38
) (
  input  sfs_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             ge
);

  logic [W:0] diff;
  logic [W-1:0] sum;

  // One subtractor gives both the difference and the unsigned compare.
  assign diff = {1'b0, a} - {1'b0, b};
  assign sum  = a + b;
  assign ge   = ~diff[W];

  always_comb begin
    unique case (op)
      sfs_pkg::ALU_ADD: res = sum;
      sfs_pkg::ALU_SUB: res = diff[W-1:0];
      default:          res = sum;
    endcase
  end

endmodule

FILE: rtl/sfs_dur_table.sv
`timescale 1ns / 1ps

module sfs_dur_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [sfs_pkg::DUR_W-1:0] wr_data,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [sfs_pkg::DUR_W-1:0] rd_data
);

  logic [sfs_pkg::DUR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid_r;
  logic [sfs_pkg::DUR_W-1:0] rd_data_r;

  // Valid bits make never-written entries read as zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sprite_frame_sequencer_core.sv
`timescale 1ns / 1ps
// Play, loop play, duration writes and ticks while idle: result in the cycle after the request.
// Tick while playing: the shared add/subtract unit works through the duration sum, the end
// test (where a stopping tick ends), the modulo when looping, the 16-step progress division
// and the frame walk, one step per cycle.
// busy is high for the whole of that work; results cannot be stalled by the receiver.
// Synchronous active-low reset: idle, not playing, path and table zero, registers 1/1/1.
module sprite_frame_sequencer_core #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sfs_pkg::CMD_W-1:0]           in_cmd,
  input  logic [sfs_pkg::NOW_W-1:0]           in_now_time,
  input  logic signed [sfs_pkg::POS_W-1:0]    in_start_x,
  input  logic signed [sfs_pkg::POS_W-1:0]    in_start_y,
  input  logic signed [sfs_pkg::POS_W-1:0]    in_end_x,
  input  logic signed [sfs_pkg::POS_W-1:0]    in_end_y,
  input  logic [sfs_pkg::ENTRY_IDX_W-1:0]     in_entry_index,
  input  logic [sfs_pkg::DUR_W-1:0]           in_entry_duration,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  output logic                                out_playing,
  output logic                                out_stopped_now,
  output logic [sfs_pkg::OUT_FRAME_W-1:0]     out_frame_index,
  output logic                                out_frame_changed,
  output logic signed [sfs_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [sfs_pkg::POS_W-1:0]    out_pos_y
);

  localparam int POS_W  = sfs_pkg::POS_W;
  localparam int PROG_W = sfs_pkg::PROG_W;
  localparam int PROD_W = sfs_pkg::PROD_W;
  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int FC_MAX = (1 << sfs_pkg::FC_W) - 1;
  localparam int NMAX   = (MAX_FRAMES < FC_MAX) ? MAX_FRAMES : FC_MAX;
  localparam int NW     = $clog2(NMAX + 1);
  localparam int TOT_W  = sfs_pkg::DUR_W + NW;
  localparam int AW     = ((TIME_BITS > TOT_W) ? TIME_BITS : TOT_W) + 1;
  localparam int STEP_W = $clog2(((TIME_BITS > PROG_W) ? TIME_BITS : PROG_W) + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_MOD,
    S_PROG,
    S_WALK,
    S_MULX,
    S_MULY,
    S_FIN
  } state_t;

  // Configuration registers.
  logic [sfs_pkg::FC_W-1:0]  fc_r;
  logic                      uniform_r;
  logic [sfs_pkg::DUR_W-1:0] ud_r;

  // Playback state.
  state_t                     state_r;
  logic                       playing_r;
  logic                       loop_r;
  logic [TIME_BITS-1:0]       start_time_r;
  logic signed [POS_W-1:0]    sx_r, sy_r, ex_r, ey_r;
  logic [IDX_W-1:0]           cur_r;

  // Working registers of one tick.
  logic [TIME_BITS-1:0]       e_r;
  logic [TIME_BITS-1:0]       ebits_r;
  logic [NW-1:0]              n_r;
  logic [TOT_W-1:0]           total_r;
  logic [AW-1:0]              acc_r;
  logic [PROG_W-1:0]          q_r;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           nf_r;
  logic [STEP_W-1:0]          step_r;
  logic                       changed_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [POS_W-1:0]    pos_x_r;

  // Result registers.
  logic                       out_valid_r;
  logic                       out_playing_r;
  logic                       out_stopped_r;
  logic [IDX_W-1:0]           out_frame_r;
  logic                       out_changed_r;
  logic signed [POS_W-1:0]    out_pos_x_r;
  logic signed [POS_W-1:0]    out_pos_y_r;

  // Combinational signals.
  logic                       accept;
  logic [NW-1:0]              n_eff;
  logic [IDX_W-1:0]           last_idx;
  logic                       tbl_wr_en;
  logic [IDX_W-1:0]           tbl_wr_addr;
  logic [IDX_W-1:0]           tbl_rd_addr;
  logic [sfs_pkg::DUR_W-1:0]  tbl_rd_data;
  logic [sfs_pkg::DUR_W-1:0]  dur_sel;
  sfs_pkg::alu_op_t           alu_op;
  logic [AW-1:0]              alu_a;
  logic [AW-1:0]              alu_b;
  logic [AW-1:0]              alu_res;
  logic                       alu_ge;
  logic [AW-1:0]              acc_step;
  logic signed [POS_W:0]      dx;
  logic signed [POS_W:0]      dy;
  logic signed [POS_W:0]      mul_a;
  logic signed [PROD_W-1:0]   mul_p;

  // Start plus truncated offset; the offset rounds toward zero, so toward start.
  function automatic logic signed [POS_W-1:0] lerp_pos(
    input logic signed [POS_W-1:0]  a,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] adj;
    logic signed [POS_W:0]    ofs;
    logic signed [POS_W:0]    s;
    adj = p[PROD_W-1] ? (p + PROD_W'(65535)) : p;
    ofs = adj[PROG_W+POS_W:PROG_W];
    s   = $signed({a[POS_W-1], a}) + ofs;
    return s[POS_W-1:0];
  endfunction

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Effective frame count: zero acts as one, clipped to the table depth.
  always_comb begin
    if (fc_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(fc_r) > MAX_FRAMES) begin
      n_eff = NW'(MAX_FRAMES);
    end else begin
      n_eff = NW'(fc_r);
    end
  end

  assign last_idx = IDX_W'(n_r - 1'b1);

  // Duration table; the read address runs one entry ahead of the sweep.
  assign tbl_wr_en   = accept && (in_cmd == sfs_pkg::CMD_WRITE) &&
                       (32'(in_entry_index) < MAX_FRAMES);
  assign tbl_wr_addr = IDX_W'(in_entry_index);
  assign tbl_rd_addr = ((state_r == S_SUM) || (state_r == S_WALK)) ?
                       IDX_W'(idx_r + 1'b1) : '0;

  sfs_dur_table #(
    .DEPTH (MAX_FRAMES),
    .IDX_W (IDX_W)
  ) u_dur_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (in_entry_duration),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign dur_sel = uniform_r ? ud_r : tbl_rd_data;

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    unique case (state_r)
      S_SUM: begin
        alu_op = sfs_pkg::ALU_ADD;
        alu_a  = acc_r;
        alu_b  = AW'(dur_sel);
      end
      S_CHECK: begin
        alu_op = sfs_pkg::ALU_SUB;
        alu_a  = AW'(e_r);
        alu_b  = AW'(total_r);
      end
      S_MOD: begin
        alu_op = sfs_pkg::ALU_SUB;
        alu_a  = {acc_r[AW-2:0], ebits_r[TIME_BITS-1]};
        alu_b  = AW'(total_r);
      end
      S_PROG: begin
        alu_op = sfs_pkg::ALU_SUB;
        alu_a  = {acc_r[AW-2:0], 1'b0};
        alu_b  = AW'(total_r);
      end
      S_WALK: begin
        alu_op = sfs_pkg::ALU_SUB;
        alu_a  = acc_r;
        alu_b  = AW'(dur_sel);
      end
      default: begin
        alu_op = sfs_pkg::ALU_ADD;
        alu_a  = acc_r;
        alu_b  = '0;
      end
    endcase
  end

  sfs_alu #(
    .W (AW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // Restoring step: keep the difference when it did not borrow.
  assign acc_step = alu_ge ? alu_res : alu_a;

  // One signed multiplier, used for x and then for y.
  assign dx    = $signed({ex_r[POS_W-1], ex_r}) - $signed({sx_r[POS_W-1], sx_r});
  assign dy    = $signed({ey_r[POS_W-1], ey_r}) - $signed({sy_r[POS_W-1], sy_r});
  assign mul_a = (state_r == S_MULY) ? dy : dx;
  assign mul_p = mul_a * $signed({1'b0, q_r});

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= sfs_pkg::FC_W'(1);
      uniform_r <= 1'b1;
      ud_r      <= sfs_pkg::DUR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfs_pkg::CFG_FRAME_COUNT:  fc_r      <= cfg_data[sfs_pkg::FC_W-1:0];
        sfs_pkg::CFG_UNIFORM_MODE: uniform_r <= cfg_data[0];
        sfs_pkg::CFG_UNIFORM_DUR:  ud_r      <= cfg_data[sfs_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state, playback state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      playing_r    <= 1'b0;
      loop_r       <= 1'b0;
      start_time_r <= '0;
      sx_r         <= '0;
      sy_r         <= '0;
      ex_r         <= '0;
      ey_r         <= '0;
      cur_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            // Defaults for a result given straight away.
            out_playing_r <= playing_r;
            out_stopped_r <= 1'b0;
            out_frame_r   <= cur_r;
            out_changed_r <= 1'b0;
            out_pos_x_r   <= sx_r;
            out_pos_y_r   <= sy_r;
            unique case (sfs_pkg::cmd_t'(in_cmd))
              sfs_pkg::CMD_PLAY: begin
                out_valid_r <= 1'b1;
                if (!playing_r) begin
                  sx_r          <= in_start_x;
                  sy_r          <= in_start_y;
                  ex_r          <= in_end_x;
                  ey_r          <= in_end_y;
                  start_time_r  <= TIME_BITS'(in_now_time);
                  playing_r     <= 1'b1;
                  cur_r         <= '0;
                  out_playing_r <= 1'b1;
                  out_frame_r   <= '0;
                  out_pos_x_r   <= in_start_x;
                  out_pos_y_r   <= in_start_y;
                end
              end
              sfs_pkg::CMD_LOOP: begin
                out_valid_r <= 1'b1;
                loop_r      <= 1'b1;
                if (!playing_r) begin
                  start_time_r  <= TIME_BITS'(in_now_time);
                  playing_r     <= 1'b1;
                  cur_r         <= '0;
                  out_playing_r <= 1'b1;
                  out_frame_r   <= '0;
                end
              end
              sfs_pkg::CMD_WRITE: begin
                out_valid_r <= 1'b1;
              end
              sfs_pkg::CMD_TICK: begin
                if (playing_r) begin
                  e_r     <= TIME_BITS'(in_now_time) - start_time_r;
                  n_r     <= n_eff;
                  acc_r   <= '0;
                  idx_r   <= '0;
                  state_r <= S_SUM;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        // Total duration: sum over the effective frames.
        S_SUM: begin
          acc_r <= alu_res;
          if (idx_r == last_idx) begin
            total_r <= alu_res[TOT_W-1:0];
            state_r <= S_CHECK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        // One-shot end test, then pick the path for the elapsed time.
        S_CHECK: begin
          step_r <= '0;
          if (!loop_r && alu_ge) begin
            playing_r     <= 1'b0;
            out_valid_r   <= 1'b1;
            out_playing_r <= 1'b0;
            out_stopped_r <= 1'b1;
            out_frame_r   <= cur_r;
            out_changed_r <= 1'b0;
            out_pos_x_r   <= sx_r;
            out_pos_y_r   <= sy_r;
            state_r       <= S_IDLE;
          end else if (total_r == '0) begin
            q_r     <= '0;
            nf_r    <= '0;
            state_r <= S_MULX;
          end else if (loop_r) begin
            acc_r   <= '0;
            ebits_r <= e_r;
            state_r <= S_MOD;
          end else begin
            acc_r   <= AW'(e_r);
            state_r <= S_PROG;
          end
        end

        // Elapsed time modulo the total, one dividend bit per cycle.
        S_MOD: begin
          acc_r   <= acc_step;
          ebits_r <= {ebits_r[TIME_BITS-2:0], 1'b0};
          step_r  <= step_r + 1'b1;
          if (step_r == STEP_W'(TIME_BITS - 1)) begin
            e_r     <= acc_step[TIME_BITS-1:0];
            step_r  <= '0;
            state_r <= S_PROG;
          end
        end

        // Progress in Q0.16: elapsed * 65536 / total, one quotient bit per cycle.
        S_PROG: begin
          acc_r  <= acc_step;
          q_r    <= {q_r[PROG_W-2:0], alu_ge};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(PROG_W - 1)) begin
            idx_r <= '0;
            if (e_r == '0) begin
              nf_r    <= '0;
              state_r <= S_MULX;
            end else begin
              acc_r   <= AW'(e_r);
              state_r <= S_WALK;
            end
          end
        end

        // Frame walk: subtract durations until the rest falls inside a frame or the last frame is reached.
        S_WALK: begin
          if (!alu_ge || (idx_r == last_idx)) begin
            nf_r    <= idx_r;
            state_r <= S_MULX;
          end else begin
            acc_r <= alu_res;
            idx_r <= idx_r + 1'b1;
          end
        end

        // Frame update and the x product.
        S_MULX: begin
          changed_r <= (nf_r != cur_r);
          cur_r     <= nf_r;
          prod_r    <= mul_p;
          state_r   <= S_MULY;
        end

        S_MULY: begin
          pos_x_r <= lerp_pos(sx_r, prod_r);
          prod_r  <= mul_p;
          state_r <= S_FIN;
        end

        S_FIN: begin
          out_valid_r   <= 1'b1;
          out_playing_r <= 1'b1;
          out_stopped_r <= 1'b0;
          out_frame_r   <= cur_r;
          out_changed_r <= changed_r;
          out_pos_x_r   <= pos_x_r;
          out_pos_y_r   <= lerp_pos(sy_r, prod_r);
          state_r       <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_playing       = out_playing_r;
  assign out_stopped_now   = out_stopped_r;
  assign out_frame_index   = sfs_pkg::OUT_FRAME_W'(out_frame_r);
  assign out_frame_changed = out_changed_r;
  assign out_pos_x         = out_pos_x_r;
  assign out_pos_y         = out_pos_y_r;

  // A result is only ever presented once the sequencer is back at rest.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while the sequencer is working");

  // A tick on a running animation always starts the multi-cycle work.
  a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == sfs_pkg::CMD_TICK) && playing_r) |=> busy)
    else $error("tick while playing did not start the sequencer");

  // The frame walk never starts from a remainder at or above the total.
  a_walk_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (acc_r < AW'(total_r)))
    else $error("frame walk remainder not below the total");

  // A run that stops is not reported as playing.
  a_stop_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stopped_r) |-> !out_playing_r)
    else $error("stopped result still marked as playing");

  // A frame change can only come from a tick of a running animation.
  a_change_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_changed_r) |-> (out_playing_r && !out_stopped_r))
    else $error("frame change reported without playback");

endmodule

FILE: sim/sprite_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps

module sprite_frame_sequencer_core_tb;

  localparam int CMD_W          = sfs_pkg::CMD_W;
  localparam int NOW_W          = sfs_pkg::NOW_W;
  localparam int POS_W          = sfs_pkg::POS_W;
  localparam int ENTRY_IDX_W    = sfs_pkg::ENTRY_IDX_W;
  localparam int DUR_W          = sfs_pkg::DUR_W;
  localparam int FC_W           = sfs_pkg::FC_W;
  localparam int OUT_FRAME_W    = sfs_pkg::OUT_FRAME_W;
  localparam int CFG_IDX_W      = sfs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = sfs_pkg::CFG_DATA_W;
  localparam int MAX_FRAMES_DEF = sfs_pkg::MAX_FRAMES_DEF;

  localparam int STALL_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ONESHOT_TARGET = 260;
  localparam int LOOP_TARGET    = 520;
  localparam int SHORT_TOTAL    = 4000;

  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;

  // One request as it is presented to the block.
  typedef struct {
    sfs_pkg::cmd_t            cmd;
    logic [NOW_W-1:0]         now;
    logic signed [POS_W-1:0]  sx;
    logic signed [POS_W-1:0]  sy;
    logic signed [POS_W-1:0]  ex;
    logic signed [POS_W-1:0]  ey;
    logic [ENTRY_IDX_W-1:0]   idx;
    logic [DUR_W-1:0]         dur;
  } seq_req_t;

  // One frame result as the block reports it.
  typedef struct {
    logic                     playing;
    logic                     stopped;
    logic [OUT_FRAME_W-1:0]   frame;
    logic                     changed;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } frame_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [CMD_W-1:0]              in_cmd;
  logic [NOW_W-1:0]              in_now_time;
  logic signed [POS_W-1:0]       in_start_x;
  logic signed [POS_W-1:0]       in_start_y;
  logic signed [POS_W-1:0]       in_end_x;
  logic signed [POS_W-1:0]       in_end_y;
  logic [ENTRY_IDX_W-1:0]        in_entry_index;
  logic [DUR_W-1:0]              in_entry_duration;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          out_valid;
  logic                          out_playing;
  logic                          out_stopped_now;
  logic [OUT_FRAME_W-1:0]        out_frame_index;
  logic                          out_frame_changed;
  logic signed [POS_W-1:0]       out_pos_x;
  logic signed [POS_W-1:0]       out_pos_y;

  sprite_frame_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_now_time       (in_now_time),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_entry_index    (in_entry_index),
    .in_entry_duration (in_entry_duration),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_playing       (out_playing),
    .out_stopped_now   (out_stopped_now),
    .out_frame_index   (out_frame_index),
    .out_frame_changed (out_frame_changed),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the sequencer: registers, playback state and duration table.
  logic [FC_W-1:0]          seq_fc;
  logic                     seq_umode;
  logic [DUR_W-1:0]         seq_udur;
  logic                     seq_playing;
  logic                     seq_looping;
  logic [NOW_W-1:0]         seq_start;
  logic signed [POS_W-1:0]  path_sx;
  logic signed [POS_W-1:0]  path_sy;
  logic signed [POS_W-1:0]  path_ex;
  logic signed [POS_W-1:0]  path_ey;
  logic [OUT_FRAME_W-1:0]   seq_frame;
  logic [DUR_W-1:0]         dur_tab [MAX_FRAMES_DEF];
  logic [63:0]              tab_total;

  frame_result_t expected_frames [$];
  frame_result_t seen_exp;
  int fault_count = 0;
  int sent_items = 0;
  int stall_cycles = 0;
  bit burst_no_gap = 1'b0;

  // Frame count as the block uses it: zero acts as one, large values clamp.
  function automatic int unsigned live_frames();
    if (seq_fc == 0) return 1;
    if (seq_fc > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
    return seq_fc;
  endfunction

  function automatic void refresh_total();
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < live_frames(); i++) s += dur_tab[i];
    tab_total = s;
  endfunction

  function automatic logic [63:0] run_total();
    return seq_umode ? {32'b0, seq_udur} * live_frames() : tab_total;
  endfunction

  function automatic void reset_model();
    seq_fc      = 1;
    seq_umode   = 1'b1;
    seq_udur    = 1;
    seq_playing = 1'b0;
    seq_looping = 1'b0;
    seq_start   = 0;
    path_sx     = 0;
    path_sy     = 0;
    path_ex     = 0;
    path_ey     = 0;
    seq_frame   = 0;
    for (int i = 0; i < MAX_FRAMES_DEF; i++) dur_tab[i] = 0;
    tab_total   = 0;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      sfs_pkg::CFG_FRAME_COUNT: begin
        seq_fc = val[FC_W-1:0];
        refresh_total();
      end
      sfs_pkg::CFG_UNIFORM_MODE: seq_umode = val[0];
      sfs_pkg::CFG_UNIFORM_DUR:  seq_udur = val;
      default: ;
    endcase
  endfunction

  // A play request only restarts the clock when nothing is running.
  function automatic void begin_run(input logic [NOW_W-1:0] now);
    if (!seq_playing) begin
      seq_start   = now;
      seq_playing = 1'b1;
      seq_frame   = 0;
    end
  endfunction

  // Linear interpolation with the quotient truncated towards zero.
  function automatic logic signed [POS_W-1:0] lerp(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b,
                                                   input logic [63:0] prog);
    longint d, p, q;
    d = longint'(b) - longint'(a);
    p = d * longint'(prog);
    q = longint'(a) + p / 65536;
    return q[POS_W-1:0];
  endfunction

  // Applies one accepted request to the shadow state and returns its result.
  function automatic frame_result_t advance_sequencer(input seq_req_t rq);
    frame_result_t res;
    logic [63:0] total, e, prog, r, nf;
    int unsigned n;
    logic moved, found;
    res.stopped = 1'b0;
    res.changed = 1'b0;
    moved = 1'b0;
    prog = 0;
    case (rq.cmd)
      sfs_pkg::CMD_PLAY: begin
        if (!seq_playing) begin
          path_sx = rq.sx;
          path_sy = rq.sy;
          path_ex = rq.ex;
          path_ey = rq.ey;
        end
        begin_run(rq.now);
      end
      sfs_pkg::CMD_LOOP: begin
        seq_looping = 1'b1;
        begin_run(rq.now);
      end
      sfs_pkg::CMD_WRITE: begin
        dur_tab[rq.idx] = rq.dur;
        refresh_total();
      end
      default: begin
        if (seq_playing) begin
          n = live_frames();
          total = run_total();
          e = {32'b0, rq.now - seq_start};
          if (!seq_looping) begin
            seq_playing = (e < total);
            res.stopped = !seq_playing;
          end
          if (seq_playing) begin
            nf = 0;
            if (total != 0) begin
              if (seq_looping) e = e % total;
              prog = (e << 16) / total;
              if (seq_umode) begin
                nf = e / {32'b0, seq_udur};
              end else if (e != 0) begin
                // Walk the table until the remaining time falls inside an entry.
                r = e;
                nf = n - 1;
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                  if (!found) begin
                    if (r < {32'b0, dur_tab[i]}) begin
                      nf = i;
                      found = 1'b1;
                    end else begin
                      r = r - dur_tab[i];
                    end
                  end
                end
              end
              if (nf >= n) nf = n - 1;
            end
            if (nf[OUT_FRAME_W-1:0] != seq_frame) begin
              seq_frame = nf[OUT_FRAME_W-1:0];
              res.changed = 1'b1;
            end
            moved = 1'b1;
          end
        end
      end
    endcase
    res.playing = seq_playing;
    res.frame   = seq_frame;
    if (moved) begin
      res.pos_x = lerp(path_sx, path_ex, prog);
      res.pos_y = lerp(path_sy, path_ey, prog);
    end else begin
      res.pos_x = path_sx;
      res.pos_y = path_sy;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  // Every strobed result is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_frames.size() == 0) begin
        $error("result strobed with no request outstanding");
        fault_count++;
      end else begin
        seen_exp = expected_frames.pop_front();
        check_field("playing", seen_exp.playing, out_playing);
        check_field("stopped_now", seen_exp.stopped, out_stopped_now);
        check_field("frame_index", seen_exp.frame, out_frame_index);
        check_field("frame_changed", seen_exp.changed, out_frame_changed);
        check_field("pos_x", seen_exp.pos_x, out_pos_x);
        check_field("pos_y", seen_exp.pos_y, out_pos_y);
      end
    end
  end

  // Watchdog: give up when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sprite_frame_sequencer_core_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Holds the request channel low until every expected result has arrived.
  task automatic wait_drained();
    start = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  // Sends one request, with a random gap in front of it outside bursts, and records the expected result.
  task automatic issue_request(input seq_req_t rq);
    int gap;
    if (!burst_no_gap && $urandom_range(0, 29) == 0) wait_drained();
    gap = burst_no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd            = rq.cmd;
    in_now_time       = rq.now;
    in_start_x        = rq.sx;
    in_start_y        = rq.sy;
    in_end_x          = rq.ex;
    in_end_y          = rq.ey;
    in_entry_index    = rq.idx;
    in_entry_duration = rq.dur;
    start             = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_frames.push_back(advance_sequencer(rq));
    sent_items++;
    @(negedge clk);
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    while (busy) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic seq_req_t rand_request(input sfs_pkg::cmd_t c);
    seq_req_t rq;
    rq.cmd = c;
    rq.now = $urandom;
    rq.sx  = 16'($urandom);
    rq.sy  = 16'($urandom);
    rq.ex  = 16'($urandom);
    rq.ey  = 16'($urandom);
    rq.idx = 4'($urandom);
    rq.dur = $urandom;
    return rq;
  endfunction

  task automatic send_tick(input logic [NOW_W-1:0] now);
    seq_req_t rq;
    rq = rand_request(sfs_pkg::CMD_TICK);
    rq.now = now;
    issue_request(rq);
  endtask

  task automatic send_play(input sfs_pkg::cmd_t c, input logic [NOW_W-1:0] now,
                           input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
                           input logic signed [POS_W-1:0] ex, input logic signed [POS_W-1:0] ey);
    seq_req_t rq;
    rq = rand_request(c);
    rq.now = now;
    rq.sx  = sx;
    rq.sy  = sy;
    rq.ex  = ex;
    rq.ey  = ey;
    issue_request(rq);
  endtask

  task automatic send_write(input logic [ENTRY_IDX_W-1:0] idx, input logic [DUR_W-1:0] dur);
    seq_req_t rq;
    rq = rand_request(sfs_pkg::CMD_WRITE);
    rq.idx = idx;
    rq.dur = dur;
    issue_request(rq);
  endtask

  // Any request with random content; loop play is held back until looping is tested.
  task automatic send_noise(input bit allow_loop);
    int c;
    c = $urandom_range(0, allow_loop ? 3 : 2);
    if (!allow_loop && c == int'(sfs_pkg::CMD_LOOP)) c = int'(sfs_pkg::CMD_WRITE);
    issue_request(rand_request(sfs_pkg::cmd_t'(c)));
  endtask

  // Mostly short durations so that runs finish, with the odd extreme value.
  function automatic logic [DUR_W-1:0] pick_duration(input bit nonzero);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return $urandom_range(nonzero ? 1 : 0, 40);
    if (sel == 8) return 32'hFFFF_FFFF;
    return $urandom | nonzero;
  endfunction

  // Stops a one-shot run by shrinking the total to one tick and ticking past it.
  task automatic go_idle();
    if (seq_playing && !seq_looping) begin
      write_register(sfs_pkg::CFG_UNIFORM_MODE, 1);
      write_register(sfs_pkg::CFG_FRAME_COUNT, 1);
      write_register(sfs_pkg::CFG_UNIFORM_DUR, 1);
      send_tick(seq_start + 32'd1);
    end
  endtask

  task automatic randomise_setup();
    int k;
    write_register(sfs_pkg::CFG_FRAME_COUNT, $urandom_range(1, MAX_FRAMES_DEF));
    write_register(sfs_pkg::CFG_UNIFORM_MODE, $urandom_range(0, 1));
    write_register(sfs_pkg::CFG_UNIFORM_DUR, pick_duration(1'b1));
    k = $urandom_range(0, 4);
    repeat (k) send_write(4'($urandom), pick_duration(1'b0));
  endtask

  // Ticks and table writes straight after reset leave the sprite idle at the origin.
  task automatic test_idle_after_reset();
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    send_write(4'd15, 32'hFFFF_FFFF);
    send_write(4'd0, 32'h0000_0000);
  endtask

  // A one-shot run over an empty table stops on its first tick.
  task automatic test_zero_total_run();
    write_register(sfs_pkg::CFG_UNIFORM_MODE, 0);
    send_play(sfs_pkg::CMD_PLAY, 32'h1234_5678, POS_MIN, POS_MIN, POS_MAX, POS_MAX);
    send_tick(32'h1234_5678);
    send_tick(32'h1234_5679);
  endtask

  // Uniform frames across a time wrap, a repeated play, the stop, and the widest duration.
  task automatic test_uniform_oneshot();
    write_register(sfs_pkg::CFG_UNIFORM_MODE, 1);
    write_register(sfs_pkg::CFG_FRAME_COUNT, 4);
    write_register(sfs_pkg::CFG_UNIFORM_DUR, 10);
    send_play(sfs_pkg::CMD_PLAY, 32'hFFFF_FFFB, POS_MAX, POS_MIN, POS_MIN, POS_MAX);
    send_play(sfs_pkg::CMD_PLAY, 32'h0000_0100, 16'sd0, 16'sd0, 16'sd100, 16'sd100);
    send_tick(32'hFFFF_FFFB);
    send_tick(32'h0000_0004);
    send_tick(32'h0000_0005);
    send_tick(32'h0000_0014);
    send_tick(32'h0000_0022);
    send_tick(32'h0000_0023);
    send_tick(32'h0000_0024);
    write_register(sfs_pkg::CFG_FRAME_COUNT, MAX_FRAMES_DEF);
    write_register(sfs_pkg::CFG_UNIFORM_DUR, 32'hFFFF_FFFF);
    send_play(sfs_pkg::CMD_PLAY, 32'h0000_0000, POS_MIN, POS_MAX, POS_MAX, POS_MIN);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    go_idle();
  endtask

  // Random one-shot runs: set up, play, then ticks that walk towards the end.
  task automatic test_random_oneshot();
    logic [63:0] tot;
    logic [NOW_W-1:0] t0, off;
    int m;
    while (sent_items < ONESHOT_TARGET) begin
      go_idle();
      burst_no_gap = ($urandom_range(0, 3) == 0);
      randomise_setup();
      t0 = $urandom;
      send_play(sfs_pkg::CMD_PLAY, t0, 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
      tot = run_total();
      m = $urandom_range(3, 12);
      off = 0;
      repeat (m) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise(1'b0);
        end else begin
          if (tot > SHORT_TOTAL) off = $urandom;
          else off = off + $urandom_range(0, 2 * 32'(tot) / m + 2);
          send_tick(t0 + off);
        end
      end
    end
    burst_no_gap = 1'b0;
    go_idle();
  endtask

  // Looping over the table: zero-length entries, wrap of elapsed time, empty
  // total, and frame counts below and above the legal range.
  task automatic test_table_loop();
    write_register(sfs_pkg::CFG_UNIFORM_MODE, 0);
    write_register(sfs_pkg::CFG_FRAME_COUNT, 3);
    send_write(4'd0, 32'd5);
    send_write(4'd1, 32'd0);
    send_write(4'd2, 32'd7);
    send_play(sfs_pkg::CMD_PLAY, 32'hFFFF_FFF8, POS_MIN, POS_MAX, POS_MAX, POS_MIN);
    send_play(sfs_pkg::CMD_LOOP, $urandom, 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    send_tick(32'hFFFF_FFF8);
    send_tick(32'hFFFF_FFFD);
    send_tick(32'h0000_0003);
    send_tick(32'h0000_0004);
    send_tick(32'h0000_000F);
    send_write(4'd0, 32'd0);
    send_write(4'd2, 32'd0);
    send_tick($urandom);
    write_register(sfs_pkg::CFG_FRAME_COUNT, 0);
    send_write(4'd0, 32'd3);
    send_tick(32'hFFFF_FFFA);
    write_register(sfs_pkg::CFG_FRAME_COUNT, 31);
    write_register(sfs_pkg::CFG_UNIFORM_MODE, 1);
    write_register(sfs_pkg::CFG_UNIFORM_DUR, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFF7);
  endtask

  // Random settings while looping: ticks near the start and anywhere in time.
  task automatic test_random_loop();
    logic [63:0] tot;
    int m;
    while (sent_items < LOOP_TARGET) begin
      burst_no_gap = ($urandom_range(0, 3) == 0);
      randomise_setup();
      tot = run_total();
      m = $urandom_range(3, 12);
      repeat (m) begin
        if ($urandom_range(0, 9) == 0) send_noise(1'b1);
        else if (tot == 0 || tot > SHORT_TOTAL || $urandom_range(0, 1) == 0) send_tick($urandom);
        else send_tick(seq_start + $urandom_range(0, 3 * 32'(tot)));
      end
    end
    burst_no_gap = 1'b0;
  endtask

  // Reset, run each test in turn, then let the pipeline drain before the verdict.
  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_cmd            = sfs_pkg::CMD_TICK;
    in_now_time       = '0;
    in_start_x        = '0;
    in_start_y        = '0;
    in_end_x          = '0;
    in_end_y          = '0;
    in_entry_index    = '0;
    in_entry_duration = '0;
    cfg_valid         = 1'b0;
    cfg_index         = sfs_pkg::CFG_FRAME_COUNT;
    cfg_data          = '0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_after_reset();
    test_zero_total_run();
    test_uniform_oneshot();
    test_random_oneshot();
    test_table_loop();
    test_random_loop();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("sprite_frame_sequencer_core_tb: clean");
    end else begin
      $display("sprite_frame_sequencer_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sfs_pkg.sv
rtl/sfs_alu.sv
rtl/sfs_dur_table.sv
rtl/sprite_frame_sequencer_core.sv
sim/sprite_frame_sequencer_core_tb.sv
